// ----- src/gwu_pkg.sv -----
// Package for the gridworld expected-utility block: cell word layout, memory
// request struct, operation, action, status and register codes.
// No dependencies; used by gwu_store and gridworld_expected_utility.
package gwu_pkg;

  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int DIM_W    = 7;   // holds grid sizes up to 64
  localparam int UTIL_W   = 32;
  localparam int PROB_W   = 17;
  localparam int GRID_W   = 6;
  localparam int COORD_W  = 6;

  // Operation codes (func)
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_WALL  = 3'd1;
  localparam logic [2:0] FUNC_TERM  = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_EU    = 3'd4;

  // Actions
  localparam logic [2:0] ACT_UP    = 3'd0;
  localparam logic [2:0] ACT_DOWN  = 3'd1;
  localparam logic [2:0] ACT_LEFT  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;

  // Neighbour directions
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // Result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_WALL = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_PROB_INT = 3'd0;
  localparam logic [2:0] CFG_PROB_CCW = 3'd1;
  localparam logic [2:0] CFG_PROB_CW  = 3'd2;
  localparam logic [2:0] CFG_COLS     = 3'd3;
  localparam logic [2:0] CFG_ROWS     = 3'd4;

  typedef struct packed {
    logic                     wall;
    logic                     term;
    logic signed [UTIL_W-1:0] util;
  } cell_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             word;
  } wr_t;

  // Direction of the k-th looked-up neighbour: intended, then the
  // counter-clockwise slip, then the clockwise slip.
  function automatic logic [2:0] nb_dir(input logic [2:0] act, input logic [1:0] k);
    logic [2:0] d;
    d = DIR_NONE;
    case (act)
      ACT_UP:    d = (k == 2'd0) ? DIR_UP    : (k == 2'd1) ? DIR_LEFT  : DIR_RIGHT;
      ACT_DOWN:  d = (k == 2'd0) ? DIR_DOWN  : (k == 2'd1) ? DIR_RIGHT : DIR_LEFT;
      ACT_LEFT:  d = (k == 2'd0) ? DIR_LEFT  : (k == 2'd1) ? DIR_DOWN  : DIR_UP;
      ACT_RIGHT: d = (k == 2'd0) ? DIR_RIGHT : (k == 2'd1) ? DIR_UP    : DIR_DOWN;
      default:   d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

// ----- src/gwu_store.sv -----
// Cell store of the gridworld block: one synchronous memory of cell words
// (utility, wall and terminal marks) with a clearing sweep after reset.
// Depends on gwu_pkg.
module gwu_store (
  input  logic                        clk,
  input  logic                        rst,
  input  gwu_pkg::wr_t                wr,
  input  logic                        rd_en,
  input  logic [gwu_pkg::ADDR_W-1:0]  rd_addr,
  output gwu_pkg::cell_t              rd_data,
  output logic                        busy
);
  import gwu_pkg::*;

  cell_t             mem [CELLS];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(CELLS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/gridworld_expected_utility.sv -----
// Top level of the gridworld expected-utility block: stream ports, register
// file, operation sequencer and the weighted-sum datapath.
// Depends on gwu_pkg and gwu_store.

// The block keeps a grid of up to 32 by 32 cells, each with a signed Q16.16
// utility, a wall mark and a terminal mark, in a single one-port-read,
// one-port-write memory. One input transaction carries one operation and
// yields exactly one output transaction. After reset the memory is swept to
// zero, one cell a cycle; no input transaction is taken during the sweep,
// while register writes are. Writes, wall and terminal marks and reads pass
// from acceptance to a result in the output register in these steps: accept
// and read the cell, modify and write back, then load the output. In an
// expected-utility query, after the addressed cell is read, the three
// neighbours are fetched one per cycle from the same memory port, each read
// feeding one 32 by 18 bit multiply, and the products are summed, rounded
// half up and saturated in the following cycles. Bad coordinates and unknown
// operations go straight from acceptance to loading the output. Operations are
// handled one at a time, so each write-back has landed before the next
// operation reads; a result waiting in the output register does not block the
// next input transaction, only the loading of its own result.
module gridworld_expected_utility (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cell_col[5:0], cell_row[11:6], action[14:12],
                                      // value[46:15], zero[47]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data[31:0]
  output logic [2:0]  m_axis_tuser,   // status[1:0], is_terminal[2]
  // Register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import gwu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HERE = 4'd1;
  localparam logic [3:0] S_N0   = 4'd2;
  localparam logic [3:0] S_N1   = 4'd3;
  localparam logic [3:0] S_N2   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_RND  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  localparam int FRAC_W = 16;
  localparam int PROD_W = UTIL_W + PROB_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) <<< (UTIL_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(1) <<< (UTIL_W - 1));

  // Configuration registers
  logic [PROB_W-1:0] prob_int, prob_ccw, prob_cw;
  logic [GRID_W-1:0] grid_cols, grid_rows;

  // Sequencer and latched operation
  logic [3:0]               state, state_next;
  logic [2:0]               func_q, action_q;
  logic [COORD_W-1:0]       col_q, row_q;
  logic signed [UTIL_W-1:0] value_q;
  logic [ADDR_W-1:0]        here_addr_q;
  logic signed [UTIL_W-1:0] here_util;
  logic                     nb_ok_q;

  // Datapath
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [UTIL_W-1:0]        res_data;
  logic [1:0]               res_status;
  logic                     res_term;

  // Memory interface
  wr_t               mem_wr;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  cell_t             mem_rd_data;
  logic              mem_busy;

  gwu_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  // Input field views
  logic [2:0]         in_func, in_action;
  logic [COORD_W-1:0] in_col, in_row, in_col0, in_row0;
  logic               in_accept, in_bad;
  logic [DIM_W-1:0]   used_cols, used_rows;

  assign in_func   = s_axis_tuser;
  assign in_col    = s_axis_tdata[5:0];
  assign in_row    = s_axis_tdata[11:6];
  assign in_action = s_axis_tdata[14:12];
  assign in_col0   = in_col - COORD_W'(1);
  assign in_row0   = in_row - COORD_W'(1);

  // Sizes above the maximum act as the maximum.
  assign used_cols = (DIM_W'(grid_cols) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                            : DIM_W'(grid_cols);
  assign used_rows = (DIM_W'(grid_rows) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                            : DIM_W'(grid_rows);

  assign in_bad = (in_col == '0) || (DIM_W'(in_col) > used_cols) ||
                  (in_row == '0) || (DIM_W'(in_row) > used_rows);

  assign s_axis_tready = (state == S_IDLE) && !mem_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Neighbour lookup for the read issued in this state.
  logic [1:0]         nb_k;
  logic [2:0]         dir;
  logic               nb_ok;
  logic [COORD_W-1:0] nb_c, nb_r;
  logic [ADDR_W-1:0]  nb_addr;

  always_comb begin
    nb_k = 2'd0;
    if (state == S_N0) begin
      nb_k = 2'd1;
    end else if (state == S_N1) begin
      nb_k = 2'd2;
    end
    dir   = nb_dir(action_q, nb_k);
    nb_ok = 1'b0;
    nb_c  = col_q;
    nb_r  = row_q;
    case (dir)
      DIR_UP: begin
        nb_ok = (DIM_W'(row_q) + DIM_W'(1)) < used_rows;
        nb_r  = row_q + COORD_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = (row_q != '0);
        nb_r  = row_q - COORD_W'(1);
      end
      DIR_LEFT: begin
        nb_ok = (col_q != '0);
        nb_c  = col_q - COORD_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (DIM_W'(col_q) + DIM_W'(1)) < used_cols;
        nb_c  = col_q + COORD_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_addr = ADDR_W'(int'(nb_r) * MAX_COLS + int'(nb_c));
  end

  // Utility that stands for the neighbour just read: the cell's own utility
  // replaces one that is off the grid or a wall.
  logic signed [UTIL_W-1:0] nb_util;
  logic [PROB_W-1:0]        nb_prob;
  logic signed [PROD_W-1:0] prod_next;
  logic                     out_free;

  assign nb_util = (nb_ok_q && !mem_rd_data.wall) ? mem_rd_data.util : here_util;

  always_comb begin
    nb_prob = prob_int;
    if (state == S_N1) begin
      nb_prob = prob_ccw;
    end else if (state == S_N2) begin
      nb_prob = prob_cw;
    end
  end

  assign prod_next = nb_util * $signed({1'b0, nb_prob});
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Rounding, half toward plus infinity, and saturation.
  logic signed [ACC_W-1:0] rnd_sum, rnd_q;
  logic [UTIL_W-1:0]       sat_val;

  always_comb begin
    rnd_sum = acc + RND_HALF;
    rnd_q   = rnd_sum >>> FRAC_W;
    if (rnd_q > SAT_MAX) begin
      sat_val = SAT_MAX[UTIL_W-1:0];
    end else if (rnd_q < SAT_MIN) begin
      sat_val = SAT_MIN[UTIL_W-1:0];
    end else begin
      sat_val = rnd_q[UTIL_W-1:0];
    end
  end

  // Memory requests and next state.
  always_comb begin
    state_next       = state;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = nb_addr;
    mem_wr.en        = 1'b0;
    mem_wr.addr      = here_addr_q;
    mem_wr.word      = mem_rd_data;
    unique case (state)
      S_IDLE: begin
        mem_rd_addr = ADDR_W'(int'(in_row0) * MAX_COLS + int'(in_col0));
        if (in_accept) begin
          if (in_func > FUNC_EU || in_bad) begin
            state_next = S_DONE;
          end else begin
            mem_rd_en  = 1'b1;
            state_next = S_HERE;
          end
        end
      end
      S_HERE: begin
        state_next = S_DONE;
        case (func_q)
          FUNC_WRITE: begin
            mem_wr.en        = 1'b1;
            mem_wr.word.util = value_q;
          end
          FUNC_WALL: begin
            mem_wr.en        = 1'b1;
            mem_wr.word.wall = 1'b1;
          end
          FUNC_TERM: begin
            mem_wr.en        = 1'b1;
            mem_wr.word.term = 1'b1;
            mem_wr.word.util = value_q;
          end
          FUNC_EU: begin
            mem_rd_en  = 1'b1;
            state_next = S_N0;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_N0: begin
        mem_rd_en  = 1'b1;
        state_next = S_N1;
      end
      S_N1: begin
        mem_rd_en  = 1'b1;
        state_next = S_N2;
      end
      S_N2:  state_next = S_SUM;
      S_SUM: state_next = S_RND;
      S_RND: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      prob_int      <= PROB_W'(52429);
      prob_ccw      <= PROB_W'(6554);
      prob_cw       <= PROB_W'(6554);
      grid_cols     <= GRID_W'(4);
      grid_rows     <= GRID_W'(3);
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROB_INT: prob_int  <= cfg_data;
          CFG_PROB_CCW: prob_ccw  <= cfg_data;
          CFG_PROB_CW:  prob_cw   <= cfg_data;
          CFG_COLS:     grid_cols <= cfg_data[GRID_W-1:0];
          CFG_ROWS:     grid_rows <= cfg_data[GRID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q      <= in_func;
      col_q       <= in_col0;
      row_q       <= in_row0;
      action_q    <= in_action;
      value_q     <= $signed(s_axis_tdata[46:15]);
      here_addr_q <= mem_rd_addr;
      res_data    <= '0;
      res_term    <= 1'b0;
      res_status  <= (in_func <= FUNC_EU && in_bad) ? ST_BAD : ST_OK;
    end
    if (state == S_HERE) begin
      here_util <= mem_rd_data.util;
      if (func_q == FUNC_READ) begin
        if (mem_rd_data.wall) begin
          res_status <= ST_WALL;
        end else begin
          res_data <= mem_rd_data.util;
          res_term <= mem_rd_data.term;
        end
      end
    end
    if (mem_rd_en) begin
      nb_ok_q <= nb_ok;
    end
    if (state == S_N0 || state == S_N1 || state == S_N2) begin
      prod <= prod_next;
    end
    if (state == S_N1) begin
      acc <= ACC_W'(prod);
    end else if (state == S_N2 || state == S_SUM) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_RND) begin
      res_data <= sat_val;
    end
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= {res_term, res_status};
    end
  end

  // Assertions
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("input accepted while an operation is in flight");

  a_write_only_in_modify: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> (state == S_HERE && func_q != FUNC_READ && func_q != FUNC_EU))
    else $error("memory write outside the modify step of a write operation");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !in_accept && !mem_wr.en)
    else $error("traffic to the cell store during the clearing sweep");

  a_error_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] != ST_OK) |->
      (m_axis_tdata == '0 && !m_axis_tuser[2]))
    else $error("error result carries data or a terminal mark");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
    else $error("undefined status code on output");

endmodule
